>>> src/dcpp_pkg.sv
// Shared types, codes and the function-code decode table for the packet parser.
package dcpp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_CMD    = 2'd0;
   localparam logic [1:0] KIND_TEXT   = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   // Function codes
   localparam logic [7:0] FUNC_SCREEN_INFO = 8'h99;
   localparam logic [7:0] FUNC_CLEAR       = 8'h00;
   localparam logic [7:0] FUNC_LINE_A      = 8'h01;
   localparam logic [7:0] FUNC_LINE_B      = 8'h02;
   localparam logic [7:0] FUNC_TRI_A       = 8'h03;
   localparam logic [7:0] FUNC_TRI_B       = 8'h04;
   localparam logic [7:0] FUNC_RECT_A      = 8'h05;
   localparam logic [7:0] FUNC_RECT_B      = 8'h06;
   localparam logic [7:0] FUNC_RRECT       = 8'h0B;
   localparam logic [7:0] FUNC_STR_A       = 8'h14;
   localparam logic [7:0] FUNC_STR_B       = 8'h15;
   localparam logic [7:0] FUNC_STR_C       = 8'h16;
   localparam logic [7:0] FUNC_PRINT       = 8'h17;
   localparam logic [7:0] FUNC_CIRCLE      = 8'h19;
   localparam logic [7:0] FUNC_ELLIPSE_A   = 8'h20;
   localparam logic [7:0] FUNC_ELLIPSE_B   = 8'h21;

   // Packet length bounds and header layout
   localparam logic [7:0] MIN_LEN   = 8'd3;
   localparam int         HDR_FIRST = 2;    // function code byte
   localparam int         HDR_LAST  = 14;   // last fixed parameter byte
   localparam int         NPARAM    = 6;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_COLLECT,
      ST_DECODE,
      ST_TEXT_RD,
      ST_TEXT
   } state_type;

   typedef struct packed {
      logic       known;
      logic [3:0] need;       // minimum packet length
      logic [2:0] np;         // big-endian parameters to report
      logic       p2_byte;    // third parameter is the single byte at offset 7
      logic       is_info;
      logic       has_text;
      logic [3:0] text_from;
   } func_info_type;

   typedef struct packed {
      logic hunt_accept;
      logic collect_accept;
      logic load_cmd;
      logic load_text;
   } dp_cmd_type;

   typedef struct packed {
      logic sync_hit;
      logic len_bad;
      logic frame_end;
      logic pkt_ok;
      logic text_more;
      logic text_last;
      logic out_free;
   } dp_status_type;

   function automatic func_info_type dcpp_decode(input logic [7:0] fc);
      func_info_type r;
      r = '0;
      unique case (fc) inside
         FUNC_SCREEN_INFO: begin
            r.known = 1'b1; r.need = 4'd8; r.np = 3'd3; r.p2_byte = 1'b1; r.is_info = 1'b1;
         end
         FUNC_CLEAR: begin
            r.known = 1'b1; r.need = 4'd5; r.np = 3'd1;
         end
         FUNC_LINE_A, FUNC_LINE_B, FUNC_RRECT: begin
            r.known = 1'b1; r.need = 4'd13; r.np = 3'd5;
         end
         FUNC_TRI_A, FUNC_TRI_B: begin
            r.known = 1'b1; r.need = 4'd15; r.np = 3'd6;
         end
         FUNC_RECT_A, FUNC_RECT_B, FUNC_ELLIPSE_A, FUNC_ELLIPSE_B: begin
            r.known = 1'b1; r.need = 4'd11; r.np = 3'd4;
         end
         FUNC_CIRCLE: begin
            r.known = 1'b1; r.need = 4'd9; r.np = 3'd3;
         end
         FUNC_STR_A, FUNC_STR_B, FUNC_STR_C: begin
            r.known = 1'b1; r.need = 4'd8; r.np = 3'd3; r.p2_byte = 1'b1;
            r.has_text = 1'b1; r.text_from = 4'd8;
         end
         FUNC_PRINT: begin
            r.known = 1'b1; r.need = 4'd4; r.np = 3'd0;
            r.has_text = 1'b1; r.text_from = 4'd3;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> src/dcpp_ifs.sv
// Valid/ready channel interfaces: input byte, result item and sync-byte write.
interface dcpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface dcpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  func_code;
   logic [2:0]  param_num;
   logic [15:0] param_a;
   logic [15:0] param_b;
   logic [15:0] param_c;
   logic [15:0] param_d;
   logic [15:0] param_e;
   logic [15:0] param_f;
   logic [7:0]  text_char;
   logic        last;
   modport source (output valid, output kind, output func_code, output param_num,
                   output param_a, output param_b, output param_c, output param_d,
                   output param_e, output param_f, output text_char, output last,
                   input ready);
   modport sink   (input valid, input kind, input func_code, input param_num,
                   input param_a, input param_b, input param_c, input param_d,
                   input param_e, input param_f, input text_char, input last,
                   output ready);
endinterface

interface dcpp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] sync_byte;
   modport source (output valid, output sync_byte, input ready);
   modport sink   (input valid, input sync_byte, output ready);
endinterface

>>> src/dcpp_ctrl.sv
// Packet parser controller: hunt/collect/decode/text state machine.
module dcpp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dcpp_pkg::dp_status_type status,
   output dcpp_pkg::dp_cmd_type    cmd
);
   import dcpp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_HUNT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.hunt_accept = 1'b1;
               if (status.sync_hit) state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.collect_accept = 1'b1;
               if (status.len_bad) state_in = ST_HUNT;
               else if (status.frame_end) state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.pkt_ok) begin
               state_in = ST_HUNT;
            end else if (status.out_free) begin
               cmd.load_cmd = 1'b1;
               state_in = status.text_more ? ST_TEXT_RD : ST_HUNT;
            end
         end
         ST_TEXT_RD: begin
            state_in = ST_TEXT;
         end
         ST_TEXT: begin
            if (status.out_free) begin
               cmd.load_text = 1'b1;
               state_in = status.text_last ? ST_HUNT : ST_TEXT_RD;
            end
         end
         default: state_in = ST_HUNT;
      endcase
   end

endmodule

>>> src/dcpp_dp.sv
// Packet parser datapath: byte store, header registers, decode and result register.
module dcpp_dp #(
   parameter int BUF_BYTES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_byte,
   input  dcpp_pkg::dp_cmd_type    cmd,
   output dcpp_pkg::dp_status_type status,
   dcpp_csr_if.sink                csr,
   dcpp_rsp_if.source              rsp
);
   import dcpp_pkg::*;

   localparam int IdxW = $clog2(BUF_BYTES);
   localparam int CntW = $clog2(BUF_BYTES + 1);

   logic [7:0]      sync_ff;
   logic [CntW-1:0] count_ff;
   logic [7:0]      length_ff;
   logic [7:0]      hdr_ff [HDR_FIRST:HDR_LAST];
   logic [7:0]      mem [BUF_BYTES];
   logic [IdxW-1:0] rd_addr_ff;
   logic [7:0]      rd_data_ff;

   logic            valid_ff, valid_in;
   logic [1:0]      kind_ff;
   logic [7:0]      func_ff;
   logic [2:0]      pcnt_ff;
   logic [15:0]     par_ff [NPARAM];
   logic [7:0]      char_ff;
   logic            last_ff;

   func_info_type   info;
   logic [15:0]     par [NPARAM];
   logic [8:0]      next_addr;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= 8'hAA;
      end else if (csr.valid) begin
         sync_ff <= csr.sync_byte;
      end
   end

   // Frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         length_ff <= '0;
      end else begin
         if (cmd.hunt_accept) count_ff <= CntW'(1);
         else if (cmd.collect_accept) count_ff <= count_ff + CntW'(1);
         if (cmd.collect_accept && count_ff == CntW'(1)) length_ff <= req_byte;
      end
   end

   // Fixed header bytes live in registers; every byte after the sync byte goes to the store
   always_ff @(posedge clock) begin
      for (int i = HDR_FIRST; i <= HDR_LAST; i++) begin
         if (cmd.collect_accept && count_ff == CntW'(i)) hdr_ff[i] <= req_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.collect_accept) mem[count_ff[IdxW-1:0]] <= req_byte;
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cmd) rd_addr_ff <= IdxW'(info.text_from);
      else if (cmd.load_text) rd_addr_ff <= rd_addr_ff + IdxW'(1);
   end

   always_comb begin
      info = dcpp_decode(hdr_ff[HDR_FIRST]);
      for (int i = 0; i < NPARAM; i++) begin
         par[i] = (3'(i) < info.np) ? {hdr_ff[3 + 2 * i], hdr_ff[4 + 2 * i]} : 16'h0000;
      end
      if (info.p2_byte) par[2] = {8'h00, hdr_ff[7]};
      next_addr = 9'(rd_addr_ff) + 9'd1;
   end

   always_comb begin
      status.sync_hit  = req_byte == sync_ff;
      status.len_bad   = (count_ff == CntW'(1)) &&
                         ((req_byte < MIN_LEN) || (9'(req_byte) > 9'(BUF_BYTES)));
      status.frame_end = (count_ff != CntW'(1)) &&
                         ((9'(count_ff) + 9'd1) >= {1'b0, length_ff});
      status.pkt_ok    = info.known && (length_ff >= {4'h0, info.need});
      status.text_more = info.has_text && ({4'h0, info.text_from} < length_ff);
      status.text_last = next_addr >= {1'b0, length_ff};
      status.out_free  = !valid_ff || rsp.ready;
   end

   // Result register
   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_cmd || cmd.load_text) valid_in = 1'b1;
      else if (rsp.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cmd) begin
         kind_ff <= info.is_info ? KIND_REPORT : KIND_CMD;
         func_ff <= hdr_ff[HDR_FIRST];
         pcnt_ff <= info.np;
         for (int i = 0; i < NPARAM; i++) par_ff[i] <= par[i];
         char_ff <= 8'h00;
         last_ff <= !status.text_more;
      end else if (cmd.load_text) begin
         kind_ff <= KIND_TEXT;
         func_ff <= hdr_ff[HDR_FIRST];
         pcnt_ff <= 3'd0;
         for (int i = 0; i < NPARAM; i++) par_ff[i] <= 16'h0000;
         char_ff <= rd_data_ff;
         last_ff <= status.text_last;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.func_code   = func_ff;
   assign rsp.param_num   = pcnt_ff;
   assign rsp.param_a     = par_ff[0];
   assign rsp.param_b     = par_ff[1];
   assign rsp.param_c     = par_ff[2];
   assign rsp.param_d     = par_ff[3];
   assign rsp.param_e     = par_ff[4];
   assign rsp.param_f     = par_ff[5];
   assign rsp.text_char   = char_ff;
   assign rsp.last        = last_ff;

endmodule

>>> src/display_command_packet_parser.sv
// Top level of the length-prefixed display command packet parser.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------------
//   req_if   | in  | valid/ready        | byte_in: one raw serial byte per item
//   rsp_if   | out | valid/ready        | kind, func_code, param_num, param_a..f,
//            |     |                    | text_char, last
//   csr_if   | in  | valid/ready (rdy=1)| sync_byte: packet start byte (reset 0xAA)
//
// Cycles: packet bytes are taken one per cycle while hunting or collecting.
// After the final byte, the decode state loads the command or report item;
// each text byte then takes a store read, then a result register load.
// Input is not taken between the final byte and the last result being loaded;
// a loaded result can still wait on rsp_if.ready while hunting resumes.
// Reset is synchronous and clears the state machine, counters, sync byte and
// result valid; the packet store needs no clearing pass.
module display_command_packet_parser #(
   parameter int BUF_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   dcpp_req_if.sink   req_if,
   dcpp_rsp_if.source rsp_if,
   dcpp_csr_if.sink   csr_if
);
   import dcpp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_if.ready = req_ready;

   // State machine: hunt -> collect -> decode -> (text read / text)*
   dcpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, decode table lookup and the result register
   dcpp_dp #(
      .BUF_BYTES (BUF_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_byte (req_if.byte_in),
      .cmd      (cmd),
      .status   (status),
      .csr      (csr_if),
      .rsp      (rsp_if)
   );

endmodule

>>> src/dcpp_checker.sv
// Port-level checks on the result channel of the packet parser, plus its bind.
module dcpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  kind,
   input logic [7:0]  func_code,
   input logic [2:0]  param_num,
   input logic [15:0] param_a,
   input logic [15:0] param_b,
   input logic [15:0] param_c,
   input logic [7:0]  text_char,
   input logic        last
);
   import dcpp_pkg::*;

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(kind) && $stable(func_code) &&
      $stable(text_char) && $stable(last) && $stable(param_a))
      else $error("result payload changed while stalled");

   a_text_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_TEXT |-> param_num == 3'd0 && param_a == 16'h0000 &&
      param_b == 16'h0000 && param_c == 16'h0000)
      else $error("text item carries parameters");

   a_report_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_REPORT |-> last && param_num == 3'd3 &&
      func_code == FUNC_SCREEN_INFO && param_c[15:8] == 8'h00)
      else $error("malformed geometry report");

endmodule

bind display_command_packet_parser dcpp_checker u_dcpp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .kind        (rsp_if.kind),
   .func_code   (rsp_if.func_code),
   .param_num   (rsp_if.param_num),
   .param_a     (rsp_if.param_a),
   .param_b     (rsp_if.param_b),
   .param_c     (rsp_if.param_c),
   .text_char   (rsp_if.text_char),
   .last        (rsp_if.last)
);
